// ===== design/ptd_pkg.sv =====
package ptd_pkg;

   localparam int SLOTS           = 16;
   localparam int SLOT_W          = $clog2(SLOTS);
   localparam int DEFAULT_WORKERS = 4;
   localparam int MAX_WORKERS     = 64;
   localparam int PRIORITY_BITS   = 3;
   localparam int MAX_RESULTS     = 16;

   typedef enum logic [2:0] {
      CMD_ADD        = 3'd0,
      CMD_CANCEL     = 3'd1,
      CMD_FINISH     = 3'd2,
      CMD_ADD_WORKER = 3'd3,
      CMD_DEL_WORKER = 3'd4
   } command_type;

   typedef enum logic [2:0] {
      ST_EMPTY     = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_RUNNING   = 3'd2,
      ST_COMPLETE  = 3'd3,
      ST_CANCELLED = 3'd4
   } slot_status_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_OCCUPIED = 2'd1,
      ERR_NOT_RUN  = 2'd2
   } error_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_CMD,
      FSM_CHECK,
      FSM_SCAN,
      FSM_DECIDE,
      FSM_FINISH,
      FSM_SEND_MORE,
      FSM_SEND_LAST
   } fsm_type;

endpackage

// ===== design/priority_task_dispatcher_core.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   command, slot, priority, dependency
// rsp_      out        rsp_valid/rsp_stall   dispatch, slot, last, error, counts
//
// One command: an accept state and an apply state, then rounds of a check,
// a scan over all SLOTS entries (one slot compared per cycle in the single
// priority/order comparator) and a decide. Each item but the last leaves from
// the send-more state; the last goes through the finish and send-last states.
// A command ends when the worker limit or the result bound is reached or when
// a scan finds nothing ready; with no dispatch it gets a bare acknowledgement.
// Reset (synchronous, active high) empties all slots, zeroes counters and
// sets the worker limit to its default. rsp_stall holds the block in its
// send state; req_stall is high whenever a command is in progress.
module priority_task_dispatcher_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_command,
   input  logic [3:0] req_task_slot,
   input  logic [2:0] req_priority_req,
   input  logic       req_has_dependency,
   input  logic [3:0] req_dependency_slot,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_dispatched,
   output logic [3:0] rsp_dispatched_slot,
   output logic       rsp_last,
   output logic [1:0] rsp_error,
   output logic [4:0] rsp_active_count,
   output logic [6:0] rsp_current_worker_limit
);

   localparam int SW = ptd_pkg::SLOT_W;
   localparam int PB = ptd_pkg::PRIORITY_BITS;

   ptd_pkg::fsm_type state_ff, state_in;

   // slot table
   ptd_pkg::slot_status_type status_ff [ptd_pkg::SLOTS];
   ptd_pkg::slot_status_type status_in [ptd_pkg::SLOTS];
   logic [PB-1:0] prio_ff  [ptd_pkg::SLOTS];
   logic [31:0]   order_ff [ptd_pkg::SLOTS];
   logic          depv_ff  [ptd_pkg::SLOTS];
   logic [3:0]    depi_ff  [ptd_pkg::SLOTS];
   logic          wr_en;

   logic [31:0] arrival_ff, arrival_in;
   logic [4:0]  running_ff, running_in;
   logic [6:0]  limit_ff, limit_in;

   // captured command
   logic [2:0]    cmd_ff;
   logic [3:0]    slot_ff;
   logic [PB-1:0] cprio_ff;
   logic          cdepv_ff;
   logic [3:0]    cdepi_ff;
   logic [1:0]    err_ff, err_in;

   // scan and pending-result tracking
   logic [SW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic [SW-1:0] best_ff, best_in;
   logic [PB-1:0] bprio_ff, bprio_in;
   logic [31:0]   border_ff, border_in;
   logic [4:0]    ndisp_ff, ndisp_in;
   logic          pend_ff, pend_in;
   logic [3:0]    pslot_ff, pslot_in;
   logic [4:0]    pcount_ff, pcount_in;

   // result register
   logic       r_disp_ff, r_disp_in;
   logic [3:0] r_slot_ff, r_slot_in;
   logic       r_last_ff, r_last_in;
   logic [4:0] r_count_ff, r_count_in;

   logic [ptd_pkg::SLOTS-1:0] complete_vec;
   logic                      slot_ok;
   logic                      cand, better;
   logic [SW-1:0]             tslot;

   always_comb begin
      for (int k = 0; k < ptd_pkg::SLOTS; k++) begin
         complete_vec[k] = (status_ff[k] == ptd_pkg::ST_COMPLETE);
      end
   end

   assign slot_ok = ({1'b0, slot_ff} < 5'(ptd_pkg::SLOTS));
   assign tslot   = slot_ff[SW-1:0];

   // candidate at the scan index: queued and its dependency complete
   always_comb begin
      cand = (status_ff[idx_ff] == ptd_pkg::ST_QUEUED) &&
             (!depv_ff[idx_ff] ||
              (({1'b0, depi_ff[idx_ff]} < 5'(ptd_pkg::SLOTS)) &&
               complete_vec[depi_ff[idx_ff][SW-1:0]]));
      better = !found_ff || (prio_ff[idx_ff] > bprio_ff) ||
               ((prio_ff[idx_ff] == bprio_ff) && (order_ff[idx_ff] < border_ff));
   end

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      arrival_in = arrival_ff;
      running_in = running_ff;
      limit_in   = limit_ff;
      err_in     = err_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      bprio_in   = bprio_ff;
      border_in  = border_ff;
      ndisp_in   = ndisp_ff;
      pend_in    = pend_ff;
      pslot_in   = pslot_ff;
      pcount_in  = pcount_ff;
      r_disp_in  = r_disp_ff;
      r_slot_in  = r_slot_ff;
      r_last_in  = r_last_ff;
      r_count_in = r_count_ff;
      unique case (state_ff)
         ptd_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = ptd_pkg::FSM_CMD;
            end
         end
         ptd_pkg::FSM_CMD: begin
            err_in   = ptd_pkg::ERR_NONE;
            ndisp_in = '0;
            pend_in  = 1'b0;
            unique case (cmd_ff)
               ptd_pkg::CMD_ADD: begin
                  if (slot_ok) begin
                     if (status_ff[tslot] == ptd_pkg::ST_QUEUED ||
                         status_ff[tslot] == ptd_pkg::ST_RUNNING) begin
                        err_in = ptd_pkg::ERR_OCCUPIED;
                     end else begin
                        status_in[tslot] = ptd_pkg::ST_QUEUED;
                        wr_en            = 1'b1;
                        arrival_in       = arrival_ff + 32'd1;
                     end
                  end
               end
               ptd_pkg::CMD_CANCEL: begin
                  if (slot_ok && status_ff[tslot] != ptd_pkg::ST_RUNNING) begin
                     status_in[tslot] = ptd_pkg::ST_CANCELLED;
                  end
               end
               ptd_pkg::CMD_FINISH: begin
                  if (slot_ok) begin
                     if (status_ff[tslot] == ptd_pkg::ST_RUNNING) begin
                        status_in[tslot] = ptd_pkg::ST_COMPLETE;
                        if (running_ff != '0) begin
                           running_in = running_ff - 5'd1;
                        end
                     end else begin
                        err_in = ptd_pkg::ERR_NOT_RUN;
                     end
                  end
               end
               ptd_pkg::CMD_ADD_WORKER: begin
                  if (limit_ff < 7'(ptd_pkg::MAX_WORKERS)) begin
                     limit_in = limit_ff + 7'd1;
                  end
               end
               ptd_pkg::CMD_DEL_WORKER: begin
                  if (limit_ff != '0) begin
                     limit_in = limit_ff - 7'd1;
                  end
               end
               default: begin
               end
            endcase
            state_in = ptd_pkg::FSM_CHECK;
         end
         ptd_pkg::FSM_CHECK: begin
            idx_in   = '0;
            found_in = 1'b0;
            if (ndisp_ff < 5'(ptd_pkg::MAX_RESULTS) && {2'b00, running_ff} < limit_ff) begin
               state_in = ptd_pkg::FSM_SCAN;
            end else begin
               state_in = ptd_pkg::FSM_FINISH;
            end
         end
         ptd_pkg::FSM_SCAN: begin
            if (cand && better) begin
               found_in  = 1'b1;
               best_in   = idx_ff;
               bprio_in  = prio_ff[idx_ff];
               border_in = order_ff[idx_ff];
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SW'(ptd_pkg::SLOTS - 1)) begin
               state_in = ptd_pkg::FSM_DECIDE;
            end
         end
         ptd_pkg::FSM_DECIDE: begin
            if (found_ff) begin
               status_in[best_ff] = ptd_pkg::ST_RUNNING;
               running_in         = running_ff + 5'd1;
               ndisp_in           = ndisp_ff + 5'd1;
               pend_in            = 1'b1;
               pslot_in           = 4'(best_ff);
               pcount_in          = running_ff + 5'd1;
               if (pend_ff) begin
                  // previous dispatch known not to be the final one
                  r_disp_in  = 1'b1;
                  r_slot_in  = pslot_ff;
                  r_last_in  = 1'b0;
                  r_count_in = pcount_ff;
                  state_in   = ptd_pkg::FSM_SEND_MORE;
               end else begin
                  state_in = ptd_pkg::FSM_CHECK;
               end
            end else begin
               state_in = ptd_pkg::FSM_FINISH;
            end
         end
         ptd_pkg::FSM_FINISH: begin
            r_last_in = 1'b1;
            if (pend_ff) begin
               r_disp_in  = 1'b1;
               r_slot_in  = pslot_ff;
               r_count_in = pcount_ff;
            end else begin
               r_disp_in  = 1'b0;
               r_slot_in  = '0;
               r_count_in = running_ff;
            end
            state_in = ptd_pkg::FSM_SEND_LAST;
         end
         ptd_pkg::FSM_SEND_MORE: begin
            if (!rsp_stall) begin
               state_in = ptd_pkg::FSM_CHECK;
            end
         end
         ptd_pkg::FSM_SEND_LAST: begin
            if (!rsp_stall) begin
               state_in = ptd_pkg::FSM_IDLE;
            end
         end
         default: state_in = ptd_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ptd_pkg::FSM_IDLE;
         arrival_ff <= '0;
         running_ff <= '0;
         limit_ff   <= 7'(ptd_pkg::DEFAULT_WORKERS);
         for (int k = 0; k < ptd_pkg::SLOTS; k++) begin
            status_ff[k] <= ptd_pkg::ST_EMPTY;
         end
      end else begin
         state_ff   <= state_in;
         arrival_ff <= arrival_in;
         running_ff <= running_in;
         limit_ff   <= limit_in;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ptd_pkg::FSM_IDLE && req_valid) begin
         cmd_ff   <= req_command;
         slot_ff  <= req_task_slot;
         cprio_ff <= req_priority_req[PB-1:0];
         cdepv_ff <= req_has_dependency;
         cdepi_ff <= req_dependency_slot;
      end
      if (wr_en) begin
         prio_ff[tslot]  <= cprio_ff;
         order_ff[tslot] <= arrival_ff;
         depv_ff[tslot]  <= cdepv_ff;
         depi_ff[tslot]  <= cdepi_ff;
      end
      err_ff     <= err_in;
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      bprio_ff   <= bprio_in;
      border_ff  <= border_in;
      ndisp_ff   <= ndisp_in;
      pend_ff    <= pend_in;
      pslot_ff   <= pslot_in;
      pcount_ff  <= pcount_in;
      r_disp_ff  <= r_disp_in;
      r_slot_ff  <= r_slot_in;
      r_last_ff  <= r_last_in;
      r_count_ff <= r_count_in;
   end

   assign req_stall                = (state_ff != ptd_pkg::FSM_IDLE);
   assign rsp_valid                = (state_ff == ptd_pkg::FSM_SEND_MORE) ||
                                     (state_ff == ptd_pkg::FSM_SEND_LAST);
   assign rsp_dispatched           = r_disp_ff;
   assign rsp_dispatched_slot      = r_slot_ff;
   assign rsp_last                 = r_last_ff;
   assign rsp_error                = err_ff;
   assign rsp_active_count         = r_count_ff;
   assign rsp_current_worker_limit = limit_ff;

   a_limit_bound: assert property (@(posedge clock) disable iff (reset)
      limit_ff <= 7'(ptd_pkg::MAX_WORKERS))
      else $error("worker limit above maximum");

   a_running_bound: assert property (@(posedge clock) disable iff (reset)
      running_ff <= 5'(ptd_pkg::SLOTS))
      else $error("running count above slot count");

   a_disp_bound: assert property (@(posedge clock) disable iff (reset)
      ndisp_ff <= 5'(ptd_pkg::MAX_RESULTS) || state_ff == ptd_pkg::FSM_IDLE)
      else $error("too many dispatches for one command");

   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dispatched |-> rsp_last)
      else $error("bare acknowledgement not marked last");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("block not busy after accepting a command");

endmodule

// ===== tb/tb_priority_task_dispatcher_core.sv =====
module tb_priority_task_dispatcher_core;

   // Handshake: an item moves on a rising edge with valid high and stall low.
   // Inputs change on the falling edge; outputs are sampled on the rising edge.

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_command;
   logic [3:0] req_task_slot;
   logic [2:0] req_priority_req;
   logic       req_has_dependency;
   logic [3:0] req_dependency_slot;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_dispatched;
   logic [3:0] rsp_dispatched_slot;
   logic       rsp_last;
   logic [1:0] rsp_error;
   logic [4:0] rsp_active_count;
   logic [6:0] rsp_current_worker_limit;

   priority_task_dispatcher_core dut (.*);

   typedef struct packed {
      logic       dispatched;
      logic [3:0] slot;
      logic       last;
      logic [1:0] error;
      logic [4:0] active;
      logic [6:0] limit;
   } dispatch_result_type;

   // Shadow of the task table, updated as each command is accepted.
   ptd_pkg::slot_status_type sh_status [ptd_pkg::SLOTS];
   logic [2:0]         sh_prio   [ptd_pkg::SLOTS];
   logic [31:0]        sh_order  [ptd_pkg::SLOTS];
   logic               sh_dep_ok [ptd_pkg::SLOTS];
   logic [3:0]         sh_dep    [ptd_pkg::SLOTS];
   logic [31:0]        sh_arrival;
   logic [4:0]         sh_running;
   logic [6:0]         sh_limit;

   dispatch_result_type pending_results[$];

   int  mismatches;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_rsp;       // long receiver hold-off, driven by its own process
   int  hold_cycles;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic bit task_ready(int s);
      if (!sh_dep_ok[s]) return 1'b1;
      return sh_status[sh_dep[s]] == ptd_pkg::ST_COMPLETE;
   endfunction

   function automatic int best_ready_slot();
      int best;
      best = -1;
      for (int i = 0; i < ptd_pkg::SLOTS; i++) begin
         if (sh_status[i] != ptd_pkg::ST_QUEUED || !task_ready(i)) continue;
         if (best < 0) best = i;
         else if (sh_prio[i] > sh_prio[best] ||
                  (sh_prio[i] == sh_prio[best] && sh_order[i] < sh_order[best]))
            best = i;
      end
      return best;
   endfunction

   // Apply one command to the shadow table and queue the results it causes.
   task automatic predict_dispatch(logic [2:0] cmd, logic [3:0] slot, logic [2:0] prio,
                                   logic hasdep, logic [3:0] dep);
      ptd_pkg::error_type  err;
      int                  n;
      int                  b;
      dispatch_result_type r;
      err = ptd_pkg::ERR_NONE;
      n = 0;
      unique case (cmd)
         ptd_pkg::CMD_ADD: begin
            if (sh_status[slot] == ptd_pkg::ST_QUEUED ||
                sh_status[slot] == ptd_pkg::ST_RUNNING) begin
               err = ptd_pkg::ERR_OCCUPIED;
            end else begin
               sh_status[slot] = ptd_pkg::ST_QUEUED;
               sh_prio[slot]   = prio;
               sh_order[slot]  = sh_arrival;
               sh_dep_ok[slot] = hasdep;
               sh_dep[slot]    = dep;
               sh_arrival++;
            end
         end
         ptd_pkg::CMD_CANCEL: begin
            if (sh_status[slot] != ptd_pkg::ST_RUNNING) sh_status[slot] = ptd_pkg::ST_CANCELLED;
         end
         ptd_pkg::CMD_FINISH: begin
            if (sh_status[slot] == ptd_pkg::ST_RUNNING) begin
               sh_status[slot] = ptd_pkg::ST_COMPLETE;
               if (sh_running > 0) sh_running--;
            end else begin
               err = ptd_pkg::ERR_NOT_RUN;
            end
         end
         ptd_pkg::CMD_ADD_WORKER: begin
            if (sh_limit < ptd_pkg::MAX_WORKERS) sh_limit++;
         end
         ptd_pkg::CMD_DEL_WORKER: begin
            if (sh_limit > 0) sh_limit--;
         end
         default: ;
      endcase
      while (n < ptd_pkg::MAX_RESULTS && sh_running < sh_limit) begin
         b = best_ready_slot();
         if (b < 0) break;
         sh_status[b] = ptd_pkg::ST_RUNNING;
         sh_running++;
         r = '{1'b1, 4'(b), 1'b0, err, sh_running, sh_limit};
         pending_results = {pending_results, r};
         n++;
      end
      if (n == 0) begin
         r = '{1'b0, 4'd0, 1'b1, err, sh_running, sh_limit};
         pending_results = {pending_results, r};
      end else begin
         pending_results[pending_results.size() - 1].last = 1'b1;
      end
   endtask

   // Drive one command and hold it until taken; prediction happens at acceptance.
   // Starts at a later falling edge than the one where the previous command dropped valid.
   task automatic send_command(logic [2:0] cmd, logic [3:0] slot, logic [2:0] prio,
                               logic hasdep, logic [3:0] dep);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_task_slot       <= slot;
      req_priority_req    <= prio;
      req_has_dependency  <= hasdep;
      req_dependency_slot <= dep;
      do @(posedge clock); while (req_stall);
      predict_dispatch(cmd, slot, prio, hasdep, dep);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Random command mix. Mostly adds and finishes of running slots so tasks
   // actually flow; cancels, worker changes, bad finishes and odd codes too.
   task automatic random_commands(int count);
      int          pick;
      logic [3:0]  s;
      int          running_slots[$];
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         s = 4'($urandom_range(15));
         if (pick < 40) begin
            send_command(ptd_pkg::CMD_ADD, s, 3'($urandom_range(7)),
                         $urandom_range(3) == 0, 4'($urandom_range(15)));
         end else if (pick < 70) begin
            running_slots = {};
            for (int i = 0; i < ptd_pkg::SLOTS; i++)
               if (sh_status[i] == ptd_pkg::ST_RUNNING) running_slots = {running_slots, i};
            if (running_slots.size() > 0 && $urandom_range(9) != 0)
               s = 4'(running_slots[$urandom_range(running_slots.size() - 1)]);
            send_command(ptd_pkg::CMD_FINISH, s, 3'($urandom), 1'($urandom), 4'($urandom));
         end else if (pick < 80) begin
            send_command(ptd_pkg::CMD_CANCEL, s, 3'($urandom), 1'($urandom), 4'($urandom));
         end else if (pick < 88) begin
            send_command(ptd_pkg::CMD_ADD_WORKER, s, 3'($urandom), 1'($urandom),
                         4'($urandom));
         end else if (pick < 96) begin
            send_command(ptd_pkg::CMD_DEL_WORKER, s, 3'($urandom), 1'($urandom),
                         4'($urandom));
         end else begin
            send_command(3'($urandom_range(7, 5)), s, 3'($urandom), 1'($urandom),
                         4'($urandom));
         end
      end
   endtask

   // Extremes of every field, each command, and the named special cases.
   task automatic test_directed();
      send_command(ptd_pkg::CMD_ADD, 4'd0, 3'd7, 1'b0, 4'd0);        // dispatches at once
      send_command(ptd_pkg::CMD_ADD, 4'd0, 3'd0, 1'b0, 4'd0);        // occupied slot
      send_command(ptd_pkg::CMD_FINISH, 4'd15, 3'd0, 1'b0, 4'd0);    // finish of idle slot
      send_command(ptd_pkg::CMD_ADD, 4'd15, 3'd0, 1'b1, 4'd15);      // self dependency
      send_command(ptd_pkg::CMD_ADD, 4'd14, 3'd5, 1'b1, 4'd0);       // waits on slot 0
      send_command(ptd_pkg::CMD_ADD, 4'd13, 3'd5, 1'b1, 4'd12);      // waits on cancelled
      send_command(ptd_pkg::CMD_CANCEL, 4'd12, 3'd7, 1'b1, 4'd15);   // empty slot cancelled
      send_command(ptd_pkg::CMD_FINISH, 4'd0, 3'd0, 1'b0, 4'd0);     // releases slot 14
      send_command(ptd_pkg::CMD_CANCEL, 4'd14, 3'd0, 1'b0, 4'd0);    // running: no effect
      for (int i = 0; i < 3; i++)
         send_command(ptd_pkg::CMD_DEL_WORKER, 4'd0, 3'd0, 1'b0, 4'd0);
      send_command(ptd_pkg::CMD_DEL_WORKER, 4'd0, 3'd0, 1'b0, 4'd0); // limit below running
      send_command(ptd_pkg::CMD_DEL_WORKER, 4'd0, 3'd0, 1'b0, 4'd0); // at zero: no change
      send_command(ptd_pkg::CMD_ADD, 4'd3, 3'd2, 1'b0, 4'd0);
      send_command(ptd_pkg::CMD_ADD, 4'd2, 3'd2, 1'b0, 4'd0);        // tie: earlier wins
      send_command(ptd_pkg::CMD_ADD, 4'd1, 3'd6, 1'b0, 4'd0);
      send_command(3'd5, 4'd0, 3'd0, 1'b0, 4'd0);                    // unknown command
      send_command(3'd7, 4'd15, 3'd7, 1'b1, 4'd15);
      send_command(ptd_pkg::CMD_FINISH, 4'd14, 3'd0, 1'b0, 4'd0);
      for (int i = 0; i < 4; i++)
         send_command(ptd_pkg::CMD_ADD_WORKER, 4'd0, 3'd0, 1'b0, 4'd0);
      send_command(ptd_pkg::CMD_CANCEL, 4'd15, 3'd0, 1'b0, 4'd0);
      wait_drained();
   endtask

   // Drop the limit to zero, queue a task in every slot, then raise the limit past
   // its ceiling, each added worker releasing at most one queued task; finish all.
   task automatic test_limit_extremes();
      for (int i = 0; i < ptd_pkg::SLOTS; i++)
         if (sh_status[i] == ptd_pkg::ST_RUNNING)
            send_command(ptd_pkg::CMD_FINISH, 4'(i), 3'd0, 1'b0, 4'd0);
      while (sh_limit > 0) send_command(ptd_pkg::CMD_DEL_WORKER, 4'd0, 3'd0, 1'b0, 4'd0);
      for (int i = 0; i < ptd_pkg::SLOTS; i++)
         send_command(ptd_pkg::CMD_ADD, 4'(i), 3'($urandom_range(7)), 1'b0, 4'd0);
      for (int i = 0; i < ptd_pkg::MAX_WORKERS + 2; i++)
         send_command(ptd_pkg::CMD_ADD_WORKER, 4'd0, 3'd0, 1'b0, 4'd0);
      for (int i = 0; i < ptd_pkg::SLOTS; i++)
         send_command(ptd_pkg::CMD_FINISH, 4'(i), 3'd0, 1'b0, 4'd0);
      while (sh_limit > ptd_pkg::DEFAULT_WORKERS)
         send_command(ptd_pkg::CMD_DEL_WORKER, 4'd0, 3'd0, 1'b0, 4'd0);
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering, then the sender
   // pauses until all results are in.
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            hold_cycles = 0;
            while (hold_cycles < 300) begin
               @(negedge clock);
               hold_cycles++;
            end
            hold_rsp = 1'b0;
         end
         random_commands(12);
      join
      wait_drained();
   endtask

   task automatic test_random();
      send_idle_pct = 14; recv_idle_pct = 63;
      random_commands(42);
      wait_drained();
      send_idle_pct = 63; recv_idle_pct = 14;
      random_commands(42);
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      random_commands(42);
      wait_drained();
   endtask

   // Receiver stall, decided at each falling edge.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   // Result checker.
   always @(posedge clock) begin
      dispatch_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_dispatched, rsp_dispatched_slot, rsp_last, rsp_error,
                 rsp_active_count, rsp_current_worker_limit};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      hold_rsp = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = ptd_pkg::CMD_ADD;
      req_task_slot = '0;
      req_priority_req = '0;
      req_has_dependency = 1'b0;
      req_dependency_slot = '0;
      for (int i = 0; i < ptd_pkg::SLOTS; i++) begin
         sh_status[i] = ptd_pkg::ST_EMPTY;
         sh_prio[i] = '0;
         sh_order[i] = '0;
         sh_dep_ok[i] = 1'b0;
         sh_dep[i] = '0;
      end
      sh_arrival = '0;
      sh_running = '0;
      sh_limit = 7'(ptd_pkg::DEFAULT_WORKERS);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 14; recv_idle_pct = 63;
      test_directed();
      test_limit_extremes();
      test_backpressure();
      test_random();

      repeat (50) @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/ptd_pkg.sv
design/priority_task_dispatcher_core.sv
tb/tb_priority_task_dispatcher_core.sv
